// ===== design/dual_uart_register_model_top_macros.svh =====
// Assertion macros used by the checker file.
`ifndef DUAL_UART_REGISTER_MODEL_TOP_MACROS_SVH
`define DUAL_UART_REGISTER_MODEL_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define DURM_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Implication checked on every clock edge, reset included.
`define DURM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== design/durm_pkg.sv =====
// Shared types and codes of the dual UART register model.
package durm_pkg;
  typedef enum logic [2:0] {
    ACT_READ  = 3'd0,
    ACT_WRITE = 3'd1,
    ACT_TICK  = 3'd2,
    ACT_RX    = 3'd3,
    ACT_TXDN  = 3'd4,
    ACT_PINS  = 3'd5
  } action_t;

  typedef struct packed {
    logic [2:0] action;
    logic [3:0] reg_addr;
    logic [7:0] write_data;
    logic       channel;
    logic [7:0] rx_byte;
    logic [3:0] input_pins;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       rx_accepted;
    logic       tx_start;
    logic       tx_channel;
    logic [7:0] tx_first;
    logic [7:0] tx_second;
    logic [1:0] tx_length;
    logic [5:0] irq_lines;
    logic [7:0] output_port;
  } result_t;
endpackage

// ===== design/durm_core.sv =====
// Register state of the UART register model and its combinational update, registered on step.
module durm_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  durm_pkg::item_t   item,
  output durm_pkg::result_t res
);
  import durm_pkg::*;

  logic [7:0]  mode_regs [4];
  logic [1:0]  mode_pointer;
  logic [3:0]  chan_status [2];
  logic [7:0]  rx_holder [2];
  logic [1:0]  rx_enabled, tx_enabled;
  logic [7:0]  out_port;
  logic [15:0] timer_count, timer_preset;
  logic [1:0]  timer_phase;
  logic        timer_irq_enable;
  logic [7:0]  aux_control, int_mask, int_status, pin_change_latch;
  logic [3:0]  prev_pins;
  logic [5:0]  irq_flags;

  logic [7:0]  mode_regs_next [4];
  logic [1:0]  mode_pointer_next;
  logic [3:0]  chan_status_next [2];
  logic [7:0]  rx_holder_next [2];
  logic [1:0]  rx_enabled_next, tx_enabled_next;
  logic [7:0]  out_port_next;
  logic [15:0] timer_count_next, timer_preset_next;
  logic [1:0]  timer_phase_next;
  logic        timer_irq_enable_next;
  logic [7:0]  aux_control_next, int_mask_next, int_status_next, latch_next;
  logic [3:0]  prev_pins_next;
  logic [5:0]  irq_flags_next;
  result_t     r;

  logic        ch, ach;
  logic [3:0]  ev;
  logic [2:0]  fld;
  logic [7:0]  v, txisr;
  logic [2:0]  txl, rxl;
  logic        do_change;

  always_comb begin
    mode_regs_next        = mode_regs;
    mode_pointer_next     = mode_pointer;
    chan_status_next      = chan_status;
    rx_holder_next        = rx_holder;
    rx_enabled_next       = rx_enabled;
    tx_enabled_next       = tx_enabled;
    out_port_next         = out_port;
    timer_count_next      = timer_count;
    timer_preset_next     = timer_preset;
    timer_phase_next      = timer_phase;
    timer_irq_enable_next = timer_irq_enable;
    aux_control_next      = aux_control;
    int_mask_next         = int_mask;
    int_status_next       = int_status;
    latch_next            = pin_change_latch;
    prev_pins_next        = prev_pins;
    irq_flags_next        = irq_flags;
    r                     = '0;
    do_change             = 1'b0;
    ev                    = '0;
    v                     = item.write_data;
    ach                   = item.reg_addr[3];
    ch                    = item.channel;
    fld                   = v[6:4];
    txisr                 = ach ? 8'h10 : 8'h01;
    txl                   = ach ? 3'd3 : 3'd1;
    rxl                   = ach ? 3'd2 : 3'd0;
    case (item.action)
      ACT_READ: begin
        case (item.reg_addr)
          4'd5: r.read_data = int_status;
          4'd4: begin
            r.read_data = pin_change_latch;
            latch_next = pin_change_latch & 8'h0f;
            int_status_next = int_status & 8'h7f;
            if ((int_status_next & int_mask) == 8'h00) irq_flags_next[4] = 1'b0;
          end
          4'd13: r.read_data = pin_change_latch & 8'h0f;
          4'd1, 4'd9: r.read_data = {4'h0, chan_status[ach]};
          4'd3, 4'd11: begin
            r.read_data = rx_holder[ach];
            chan_status_next[ach][0] = 1'b0;
            irq_flags_next[rxl] = 1'b0;
          end
          4'd6: r.read_data = timer_count[15:8];
          4'd7: r.read_data = timer_count[7:0];
          4'd14: begin
            timer_count_next = timer_preset;
            timer_phase_next = 2'd1;
          end
          4'd15: begin
            timer_phase_next = 2'd0;
            int_status_next = int_status & ~8'h08;
            irq_flags_next[5] = 1'b0;
            if (timer_irq_enable) out_port_next = out_port & ~8'h08;
          end
          default: ;
        endcase
      end
      ACT_WRITE: begin
        case (item.reg_addr)
          4'd0, 4'd8: begin
            mode_regs_next[{ach, mode_pointer[ach]}] = v;
            mode_pointer_next[ach] = ~mode_pointer[ach];
          end
          4'd2, 4'd10: begin
            if (fld == 3'd1 || fld == 3'd4) mode_pointer_next[ach] = 1'b0;
            if (fld == 3'd3) begin
              tx_enabled_next[ach] = 1'b0;
              int_status_next = int_status_next & ~txisr;
              chan_status_next[ach][2] = 1'b0;
              irq_flags_next[txl] = 1'b0;
            end
            if (v[0]) rx_enabled_next[ach] = 1'b1;
            if (v[1]) rx_enabled_next[ach] = 1'b0;
            if (v[2] && !tx_enabled_next[ach]) begin
              tx_enabled_next[ach] = 1'b1;
              int_status_next = int_status_next | txisr;
              chan_status_next[ach] = chan_status_next[ach] | 4'hc;
              irq_flags_next[txl] = 1'b1;
            end
            if (v[3]) begin
              tx_enabled_next[ach] = 1'b0;
              int_status_next = int_status_next & ~txisr;
              chan_status_next[ach] = (chan_status_next[ach] & ~4'h4) | 4'h8;
              irq_flags_next[txl] = 1'b0;
            end
          end
          4'd5: begin
            int_mask_next = v;
            do_change = 1'b1;
          end
          4'd4: begin
            aux_control_next = v;
            do_change = 1'b1;
          end
          4'd3, 4'd11: begin
            if ((ach && out_port[2]) || mode_regs[{ach, 1'b1}][7]) begin
              rx_holder_next[ach] = v;
              chan_status_next[ach][0] = 1'b1;
            end else begin
              r.tx_start = 1'b1;
              r.tx_channel = ach;
              if (ach) begin
                r.tx_first = {7'd0, mode_regs[2][2]};
                r.tx_second = v;
                r.tx_length = 2'd2;
              end else begin
                r.tx_first = v;
                r.tx_length = 2'd1;
              end
              chan_status_next[ach] = chan_status[ach] & ~4'hc;
              irq_flags_next[txl] = 1'b0;
            end
          end
          4'd6: timer_preset_next[15:8] = v;
          4'd7: timer_preset_next[7:0] = v;
          4'd13: timer_irq_enable_next = ((v & 8'h0c) == 8'h04);
          4'd14: begin
            out_port_next = out_port | v;
            if (out_port_next[4]) irq_flags_next[0] = 1'b1;
            if (out_port_next[5]) irq_flags_next[2] = 1'b1;
            if (out_port_next[7]) irq_flags_next[3] = 1'b1;
          end
          4'd15: begin
            out_port_next = out_port & ~v;
            if (!out_port_next[4]) irq_flags_next[0] = 1'b0;
            if (!out_port_next[5]) irq_flags_next[2] = 1'b0;
            if (!out_port_next[7]) irq_flags_next[3] = 1'b0;
          end
          default: ;
        endcase
      end
      ACT_TICK: begin
        if (timer_phase == 2'd1) begin
          timer_phase_next = 2'd2;
        end else if (timer_phase == 2'd2) begin
          timer_count_next = timer_count - 16'd1;
          if (timer_count == 16'd1) begin
            int_status_next = int_status | 8'h08;
            if (timer_irq_enable) begin
              irq_flags_next[5] = 1'b1;
              out_port_next = out_port | 8'h08;
            end
          end
        end
      end
      ACT_RX: begin
        if (rx_enabled[ch] && !chan_status[ch][0]) begin
          rx_holder_next[ch] = item.rx_byte;
          chan_status_next[ch][0] = 1'b1;
          irq_flags_next[ch ? 3'd2 : 3'd0] = 1'b1;
          r.rx_accepted = 1'b1;
        end
      end
      ACT_TXDN: begin
        chan_status_next[ch] = chan_status[ch] | 4'hc;
        if (tx_enabled[ch]) irq_flags_next[ch ? 3'd3 : 3'd1] = 1'b1;
      end
      ACT_PINS: begin
        latch_next = {pin_change_latch[7:4], item.input_pins};
        do_change = 1'b1;
      end
      default: ;
    endcase
    // Pin change detection shared by mask, aux and pin updates.
    if (do_change) begin
      if (item.action == ACT_WRITE && item.reg_addr == 4'd4) prev_pins_next = 4'h0;
      ev = (latch_next[3:0] ^ prev_pins_next);
      prev_pins_next = latch_next[3:0];
      latch_next = latch_next | {ev, 4'h0};
      if ((latch_next[7:4] & aux_control_next[3:0]) != 4'h0)
        int_status_next = int_status_next | 8'h80;
      irq_flags_next[4] = ((int_status_next & int_mask_next) != 8'h00);
    end
    r.irq_lines = irq_flags_next;
    r.output_port = out_port_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_regs        <= '{default: 8'h00};
      mode_pointer     <= '0;
      chan_status      <= '{default: 4'h0};
      rx_holder        <= '{default: 8'h00};
      rx_enabled       <= '0;
      tx_enabled       <= '0;
      out_port         <= '0;
      timer_count      <= '0;
      timer_preset     <= '0;
      timer_phase      <= '0;
      timer_irq_enable <= 1'b0;
      aux_control      <= '0;
      int_mask         <= '0;
      int_status       <= '0;
      pin_change_latch <= 8'h03;
      prev_pins        <= '0;
      irq_flags        <= '0;
    end else if (step) begin
      mode_regs        <= mode_regs_next;
      mode_pointer     <= mode_pointer_next;
      chan_status      <= chan_status_next;
      rx_holder        <= rx_holder_next;
      rx_enabled       <= rx_enabled_next;
      tx_enabled       <= tx_enabled_next;
      out_port         <= out_port_next;
      timer_count      <= timer_count_next;
      timer_preset     <= timer_preset_next;
      timer_phase      <= timer_phase_next;
      timer_irq_enable <= timer_irq_enable_next;
      aux_control      <= aux_control_next;
      int_mask         <= int_mask_next;
      int_status       <= int_status_next;
      pin_change_latch <= latch_next;
      prev_pins        <= prev_pins_next;
      irq_flags        <= irq_flags_next;
    end
  end

  assign res = r;
endmodule

// ===== design/dual_uart_register_model_top.sv =====
// Top level: input register, register model core and result register.
// Each transaction (bus access, timer tick, line event or pin change) is
// held in the input register, handled combinationally by the core, and
// its result is placed in the output register; one transaction can be
// accepted every clock while no result waits untaken. The input register
// refills while its item moves to the output, and stalls only when a
// result waits untaken.
module dual_uart_register_model_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] action,
  input  logic [3:0] reg_addr,
  input  logic [7:0] write_data,
  input  logic       channel,
  input  logic [7:0] rx_byte,
  input  logic [3:0] input_pins,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] read_data,
  output logic       rx_accepted,
  output logic       tx_start,
  output logic       tx_channel,
  output logic [7:0] tx_first,
  output logic [7:0] tx_second,
  output logic [1:0] tx_length,
  output logic [5:0] irq_lines,
  output logic [7:0] output_port
);
  import durm_pkg::*;

  item_t   item;
  logic    item_valid;
  result_t res, res_q;
  logic    step;

  // Advance the held item when the result register is free or draining.
  assign step     = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_ready) item_valid <= in_valid;
      if (step) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid)
      item <= '{action, reg_addr, write_data, channel, rx_byte, input_pins};
    if (step) res_q <= res;
  end

  durm_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (item),
    .res  (res)
  );

  assign read_data   = res_q.read_data;
  assign rx_accepted = res_q.rx_accepted;
  assign tx_start    = res_q.tx_start;
  assign tx_channel  = res_q.tx_channel;
  assign tx_first    = res_q.tx_first;
  assign tx_second   = res_q.tx_second;
  assign tx_length   = res_q.tx_length;
  assign irq_lines   = res_q.irq_lines;
  assign output_port = res_q.output_port;
endmodule

// ===== design/durm_checker.sv =====
// Port-level checker for the UART register model, bound to the top level.
`include "dual_uart_register_model_top_macros.svh"
module durm_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       tx_start,
  input logic [1:0] tx_length,
  input logic       tx_channel
);
  `DURM_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid, "result dropped")
  `DURM_ASSERT(a_tx_len, clk, rst, out_valid && !tx_start |-> tx_length == 2'd0, "stray length")
  `DURM_ASSERT(a_tx_ch, clk, rst, out_valid && tx_start |-> tx_length == {tx_channel, !tx_channel}, "bad length")
  `DURM_ASSERT(a_ready, clk, rst, !out_valid |-> in_ready, "stall while output empty")
  `DURM_ASSERT_ALWAYS(a_rst, clk, $past(rst) |-> !out_valid, "valid after reset")
endmodule

bind dual_uart_register_model_top durm_checker u_chk (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .tx_start   (tx_start),
  .tx_length  (tx_length),
  .tx_channel (tx_channel)
);
